>>> hdl/b64enc_pkg.sv
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
`default_nettype none

package b64enc_pkg;

  // Number of completed groups that can wait between the front and the back.
  localparam int unsigned GrpDepth = 2;
  localparam int unsigned GrpPtrW  = (GrpDepth > 1) ? $clog2(GrpDepth) : 1;
  localparam int unsigned GrpCntW  = $clog2(GrpDepth + 1);

  // Padding character '='.
  localparam logic [7:0] PadChar = 8'h3D;

  // Number of characters per group and index width.
  localparam int unsigned CharsPerGrp = 4;
  localparam int unsigned CharIdxW    = $clog2(CharsPerGrp);
  localparam logic [CharIdxW-1:0] LastCharIdx = CharIdxW'(CharsPerGrp - 1);

  // Input request: one raw byte and the end-of-message flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_end;
  } in_t;

  // Output request: one ASCII character with its markers.
  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       stream_last;
  } out_t;

  // Completed group handed from the front to the back.
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  pad_cnt;
    logic        msg_last;
  } grp_t;

  // Status of the group queue.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // Map a 6-bit value onto the standard base64 alphabet.
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v inside {[6'd0 : 6'd25]}) begin
      c = 8'h41 + {2'b00, v};
    end else if (v inside {[6'd26 : 6'd51]}) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v inside {[6'd52 : 6'd61]}) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/b64enc_front.sv
// Front part: collects input bytes into groups and pushes finished groups.
`default_nettype none

module b64enc_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire b64enc_pkg::in_t   in_data_i,
  input  wire b64enc_pkg::fifo_status_t fifo_st_i,
  output logic                   push_o,
  output b64enc_pkg::grp_t       push_grp_o
);
  import b64enc_pkg::*;

  logic [1:0] count_q, count_d;
  logic [7:0] byte0_q, byte1_q;
  logic       accept;
  logic       store;
  logic       full_grp;

  // Accept only while the queue has room for a possible group.
  assign in_ready_o = !fifo_st_i.full;
  assign accept     = in_valid_i && in_ready_o;
  // A count above two is treated as two.
  assign full_grp   = count_q[1];
  assign store      = accept && !full_grp && !in_data_i.message_end;
  assign push_o     = accept && !store;

  // Build the group word and its padding from what is pending.
  always_comb begin
    push_grp_o.msg_last = in_data_i.message_end;
    if (full_grp) begin
      push_grp_o.word    = {byte0_q, byte1_q, in_data_i.data_byte};
      push_grp_o.pad_cnt = 2'd0;
    end else if (count_q == 2'd1) begin
      push_grp_o.word    = {byte0_q, in_data_i.data_byte, 8'h00};
      push_grp_o.pad_cnt = 2'd1;
    end else begin
      push_grp_o.word    = {in_data_i.data_byte, 16'h0000};
      push_grp_o.pad_cnt = 2'd2;
    end
  end

  // Pending count update.
  always_comb begin
    count_d = count_q;
    if (store) begin
      count_d = count_q + 2'd1;
    end else if (push_o) begin
      count_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  // Pending bytes carry no reset.
  always_ff @(posedge clk_i) begin
    if (store && count_q == 2'd0) begin
      byte0_q <= in_data_i.data_byte;
    end
    if (store && count_q == 2'd1) begin
      byte1_q <= in_data_i.data_byte;
    end
  end

endmodule

`default_nettype wire

>>> hdl/b64enc_fifo.sv
// Short queue of completed groups between the front and the back.
`default_nettype none

module b64enc_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire b64enc_pkg::grp_t    push_grp_i,
  input  wire logic                pop_i,
  output b64enc_pkg::grp_t         head_o,
  output b64enc_pkg::fifo_status_t status_o
);
  import b64enc_pkg::*;

  grp_t                 mem_q [GrpDepth];
  logic [GrpPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [GrpPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [GrpCntW-1:0]   cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == GrpCntW'(GrpDepth));
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == GrpPtrW'(GrpDepth - 1)) ? '0 : wr_ptr_q + GrpPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == GrpPtrW'(GrpDepth - 1)) ? '0 : rd_ptr_q + GrpPtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + GrpCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - GrpCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Group storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_grp_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/b64enc_back.sv
// Back part: turns queued groups into four characters, one per cycle unless stalled.
`default_nettype none

module b64enc_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire b64enc_pkg::grp_t     head_i,
  input  wire b64enc_pkg::fifo_status_t fifo_st_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output b64enc_pkg::out_t          out_data_o
);
  import b64enc_pkg::*;

  logic [CharIdxW-1:0] idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;
  logic                load;
  logic [5:0]          sextet;
  logic                is_pad;
  logic                last_char;

  assign load      = !fifo_st_i.empty && (!out_valid_q || out_ready_i);
  assign last_char = (idx_q == LastCharIdx);
  assign pop_o     = load && last_char;

  // Pick the sextet for the current character position.
  always_comb begin
    case (idx_q)
      2'd0:    sextet = head_i.word[23:18];
      2'd1:    sextet = head_i.word[17:12];
      2'd2:    sextet = head_i.word[11:6];
      default: sextet = head_i.word[5:0];
    endcase
  end

  // Trailing positions covered by the padding count become '='.
  assign is_pad = ({1'b0, idx_q} >= (3'd4 - {1'b0, head_i.pad_cnt}));

  always_comb begin
    out_d.out_char    = is_pad ? PadChar : b64_char(sextet);
    out_d.run_last    = last_char;
    out_d.stream_last = last_char && head_i.msg_last;
  end

  // Output register valid and character index.
  always_comb begin
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = last_char ? '0 : idx_q + CharIdxW'(1);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> hdl/base64_stream_encoder.sv
// Top level of the base64 stream encoder: front, group queue and back.
//
// Usage: raw bytes enter on the in channel (in_valid_i/in_ready_o/in_data_i),
// each request carrying data_byte and message_end. ASCII characters leave on
// the out channel (out_valid_o/out_ready_i/out_data_o) with run_last on the
// last character of a group and stream_last on the last of the message.
// A byte that does not close a group is stored and produces nothing. A byte
// that closes a group, or any byte with message_end set, releases four
// characters, padded with '=' for a partial final group.
// A group closed by an accepted byte is written into the group queue, and
// its first character is then registered in the output register. The back
// emits one character per cycle while the receiver is ready, so the output
// serializer limits the throughput. Bytes are taken every cycle while the
// two-entry group queue has room.
// Reset clears the pending count, the queue and the output valid flag; the
// first request may follow right away. When the receiver stalls, the
// current character holds; the queue fills, and then in_ready_o drops.
`default_nettype none

module base64_stream_encoder (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire b64enc_pkg::in_t  in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output b64enc_pkg::out_t      out_data_o
);
  import b64enc_pkg::*;

  logic         push;
  logic         pop;
  grp_t         push_grp;
  grp_t         head_grp;
  fifo_status_t fifo_st;

  // Front: groups input bytes.
  b64enc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .fifo_st_i  (fifo_st),
    .push_o     (push),
    .push_grp_o (push_grp)
  );

  // Queue of finished groups.
  b64enc_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_grp_i (push_grp),
    .pop_i      (pop),
    .head_o     (head_grp),
    .status_o   (fifo_st)
  );

  // Back: serializes characters.
  b64enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_grp),
    .fifo_st_i   (fifo_st),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // The front never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && fifo_st.full))
    else $error("group pushed into a full queue");

  // The back never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop && fifo_st.empty))
    else $error("group popped from an empty queue");

  // The message end always falls on the last character of a group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_data_o.stream_last) |-> out_data_o.run_last)
    else $error("stream_last without run_last");

  // A pop loads a last character into the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      pop |=> (out_valid_o && out_data_o.run_last))
    else $error("group retired without a closing character");

endmodule

`default_nettype wire
